/* sv/gbf_pkg.sv */
package gbf_pkg;

  // Default display and font store geometry
  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam int FONT_WORDS_DEF  = 2048;

  // Field widths
  localparam int ACT_W    = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Actions
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [CFG_W-1:0] FONT_HEIGHT_RST = 5'd10;
  localparam logic [CFG_W-1:0] GLYPH_MAX_DIM   = 5'd16;

  // Printable code range and glyph row layout
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd126;
  localparam logic [3:0] ROW_MSB_BIT = 4'd15;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic font_load;
    logic rd_issue;
    logic rd_capture;
    logic draw_start;
    logic row_latch;
    logic col_step;
    logic row_next;
    logic reject;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             oob;
    logic             empty;
    logic             clr_last;
    logic             col_last;
    logic             row_last;
    logic             out_free;
  } sts_t;

endpackage

/* sv/gbf_in_if.sv */
interface gbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  char_code;
  logic [10:0] font_addr;
  logic [15:0] font_word;
  logic [9:0]  fb_addr;

  modport source (
    output valid, action, pos_x, pos_y, char_code, font_addr, font_word, fb_addr,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, char_code, font_addr, font_word, fb_addr,
    output ready
  );
endinterface

/* sv/gbf_out_if.sv */
interface gbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       status;

  modport source (
    output valid, read_byte, status,
    input  ready
  );
  modport sink (
    input  valid, read_byte, status,
    output ready
  );
endinterface

/* sv/gbf_ram.sv */
module gbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/gbf_ctrl.sv */
module gbf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gbf_pkg::sts_t sts,
  output gbf_pkg::cmd_t cmd
);
  import gbf_pkg::*;

  localparam logic [3:0] S_BOOT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_CLEAR  = 4'd3;
  localparam logic [3:0] S_RDWAIT = 4'd4;
  localparam logic [3:0] S_FROW   = 4'd5;
  localparam logic [3:0] S_FWAIT  = 4'd6;
  localparam logic [3:0] S_COL    = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence one item through its action
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_BOOT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          ACT_CLEAR: state_nxt = S_CLEAR;
          ACT_LOAD: begin
            cmd.font_load = 1'b1;
            state_nxt     = S_DONE;
          end
          ACT_DRAW: begin
            if (sts.oob) begin
              cmd.reject = 1'b1;
              state_nxt  = S_DONE;
            end else if (sts.empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.draw_start = 1'b1;
              state_nxt      = S_FROW;
            end
          end
          default: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RDWAIT;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_FROW: state_nxt = S_FWAIT;
      S_FWAIT: begin
        cmd.row_latch = 1'b1;
        state_nxt     = S_COL;
      end
      S_COL: begin
        cmd.col_step = 1'b1;
        if (sts.col_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.row_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = S_FROW;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/gbf_dp.sv */
module gbf_dp #(
  parameter int DISP_WIDTH  = gbf_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = gbf_pkg::DISP_HEIGHT_DEF,
  parameter int FONT_WORDS  = gbf_pkg::FONT_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbf_pkg::CFG_W-1:0]      cfg_data,
  input  gbf_pkg::cmd_t                  cmd,
  output gbf_pkg::sts_t                  sts,
  input  logic [gbf_pkg::ACT_W-1:0]      in_action,
  input  logic [7:0]                     in_pos_x,
  input  logic [7:0]                     in_pos_y,
  input  logic [7:0]                     in_char_code,
  input  logic [10:0]                    in_font_addr,
  input  logic [15:0]                    in_font_word,
  input  logic [9:0]                     in_fb_addr,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_read_byte,
  output logic                           out_status
);
  import gbf_pkg::*;

  localparam int FB_PAGES = (DISP_HEIGHT + 7) / 8;
  localparam int FB_BYTES = DISP_WIDTH * FB_PAGES;
  localparam int FB_AW    = $clog2(FB_BYTES);
  localparam int FA_W     = $clog2(FONT_WORDS);

  function automatic logic [CFG_W-1:0] clamp16(input logic [CFG_W-1:0] v);
    return (v > GLYPH_MAX_DIM) ? GLYPH_MAX_DIM : v;
  endfunction

  // Configuration
  logic [CFG_W-1:0] font_width_r;
  logic [CFG_W-1:0] font_height_r;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;

  // Latched item
  logic [ACT_W-1:0] act_r;
  logic [7:0]       px_r;
  logic [7:0]       py_r;
  logic [7:0]       code_r;
  logic [10:0]      laddr_r;
  logic [15:0]      lword_r;
  logic [9:0]       baddr_r;

  // Clear sweep and draw walk
  logic [FB_AW-1:0] clr_cnt_r;
  logic [10:0]      faddr_r;
  logic [7:0]       yy_r;
  logic [3:0]       row_cnt_r;
  logic [7:0]       col_r;
  logic [3:0]       col_cnt_r;
  logic [15:0]      row_r;
  logic             pend_r;
  logic [FB_AW-1:0] paddr_r;

  // Result
  logic [7:0]       rbyte_r;
  logic             stat_r;
  logic             out_valid_r;
  logic [7:0]       read_byte_r;
  logic             status_r;

  logic [6:0]       glyph;
  logic [10:0]      base;
  logic             frange;
  logic [FB_AW-1:0] idx;
  logic [7:0]       mask;
  logic             cur_bit;

  logic             fb_we;
  logic [FB_AW-1:0] fb_waddr;
  logic [7:0]       fb_wdata;
  logic [FB_AW-1:0] fb_raddr;
  logic [7:0]       fb_rdata;
  logic             font_we;
  logic [15:0]      font_rdata;

  assign w_eff = clamp16(font_width_r);
  assign h_eff = clamp16(font_height_r);

  // Map unprintable codes to a space, then find the first glyph row
  assign glyph  = (code_r >= GLYPH_FIRST && code_r <= GLYPH_LAST) ?
                  7'(code_r - GLYPH_FIRST) : 7'd0;
  assign base   = 11'({4'b0, glyph} * {6'b0, h_eff});
  assign frange = (32'(faddr_r) < FONT_WORDS);

  assign idx     = FB_AW'(32'(yy_r[7:3]) * DISP_WIDTH + 32'(col_r));
  assign mask    = 8'd1 << yy_r[2:0];
  assign cur_bit = row_r[ROW_MSB_BIT - col_cnt_r];

  // Status toward the controller
  always_comb begin
    sts.act      = act_r;
    sts.oob      = (32'(px_r) + 32'(w_eff) > DISP_WIDTH) ||
                   (32'(py_r) + 32'(h_eff) > DISP_HEIGHT);
    sts.empty    = (w_eff == '0) || (h_eff == '0);
    sts.clr_last = (clr_cnt_r == FB_AW'(FB_BYTES - 1));
    sts.col_last = ({1'b0, col_cnt_r} == (w_eff - 5'd1));
    sts.row_last = ({1'b0, row_cnt_r} == (h_eff - 5'd1));
    sts.out_free = !out_valid_r || out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_width_r  <= FONT_WIDTH_RST;
      font_height_r <= FONT_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FONT_WIDTH:  font_width_r  <= cfg_data;
        CFG_FONT_HEIGHT: font_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers: clear sweep, pending write, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + FB_AW'(1);
      end
      pend_r <= cmd.col_step && cur_bit;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_action;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      code_r  <= in_char_code;
      laddr_r <= in_font_addr;
      lword_r <= in_font_word;
      baddr_r <= in_fb_addr;
      rbyte_r <= '0;
      stat_r  <= 1'b0;
    end
    if (cmd.reject) stat_r <= 1'b1;
    if (cmd.rd_capture) begin
      rbyte_r <= (32'(baddr_r) < FB_BYTES) ? fb_rdata : 8'd0;
    end
    if (cmd.draw_start) begin
      faddr_r   <= base;
      yy_r      <= py_r;
      row_cnt_r <= '0;
    end
    if (cmd.row_next) begin
      faddr_r   <= faddr_r + 11'd1;
      yy_r      <= yy_r + 8'd1;
      row_cnt_r <= row_cnt_r + 4'd1;
    end
    if (cmd.row_latch) begin
      row_r     <= frange ? font_rdata : 16'd0;
      col_r     <= px_r;
      col_cnt_r <= '0;
    end
    if (cmd.col_step) begin
      paddr_r   <= idx;
      col_r     <= col_r + 8'd1;
      col_cnt_r <= col_cnt_r + 4'd1;
    end
    if (cmd.out_load) begin
      read_byte_r <= rbyte_r;
      status_r    <= stat_r;
    end
  end

  // Framebuffer port: clear sweep or OR one pixel into the fetched byte
  always_comb begin
    if (cmd.clr_step) begin
      fb_we    = 1'b1;
      fb_waddr = clr_cnt_r;
      fb_wdata = 8'd0;
    end else begin
      fb_we    = pend_r;
      fb_waddr = paddr_r;
      fb_wdata = fb_rdata | mask;
    end
  end

  assign fb_raddr = cmd.rd_issue ? FB_AW'(baddr_r) : idx;
  assign font_we  = cmd.font_load && (32'(laddr_r) < FONT_WORDS);

  gbf_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_frame_store (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  gbf_ram #(
    .WIDTH (16),
    .DEPTH (FONT_WORDS)
  ) u_font_store (
    .clk   (clk),
    .we    (font_we),
    .waddr (FA_W'(laddr_r)),
    .wdata (lword_r),
    .raddr (FA_W'(faddr_r)),
    .rdata (font_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_read_byte = read_byte_r;
  assign out_status    = status_r;

endmodule

/* sv/glyph_blit_page_framebuffer_top.sv */
// One item at a time; a draw reads one framebuffer byte per glyph column and writes it
// back with the glyph bit ORed in when set, plus a font fetch and a drain per row.
// After reset a clearing pass zeroes all FB_BYTES framebuffer bytes (1024 by default)
// with in_ch.ready low; configuration writes are taken throughout.
module glyph_blit_page_framebuffer_top #(
  parameter int DISP_WIDTH  = gbf_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = gbf_pkg::DISP_HEIGHT_DEF,
  parameter int FONT_WORDS  = gbf_pkg::FONT_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbf_pkg::CFG_W-1:0]     cfg_data,
  gbf_in_if.sink                        in_ch,
  gbf_out_if.source                     out_ch
);
  import gbf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  gbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbf_dp #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT),
    .FONT_WORDS  (FONT_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_y      (in_ch.pos_y),
    .in_char_code  (in_ch.char_code),
    .in_font_addr  (in_ch.font_addr),
    .in_font_word  (in_ch.font_word),
    .in_fb_addr    (in_ch.fb_addr),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_read_byte (out_ch.read_byte),
    .out_status    (out_ch.status)
  );

endmodule
